/* hw/rtl/rnm_pkg.sv */
// Shared types and constants for the regex NFA matcher.
// Used by rnm_cell and regex_nfa_matcher; no dependencies.
`timescale 1ns / 1ps

package rnm_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_TEXT   = 2'd3;

  localparam logic [7:0] STAR_BYTE = 8'd42;
  localparam logic [7:0] ANY_BYTE  = 8'd46;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic dropped;
  } out_item_t;

  // Per-cell control, decoded once at the top level
  typedef struct packed {
    logic wr_en;   // store a new atom in this cell
    logic star_en; // mark this cell's atom as repeatable
    logic in_use;  // cell index is below the atom count
    logic step;    // text byte: advance the frontier
    logic seed;    // start of text: position 0 becomes active
    logic upd;     // load the frontier bit with the new value
    logic clr;     // pattern op: drop the frontier bit
  } cell_ctrl_t;

endpackage

/* hw/rtl/rnm_cell.sv */
// One atom cell of the NFA chain: holds an atom and its frontier bit.
// Depends on rnm_pkg for cell_ctrl_t and the pattern byte codes.
`timescale 1ns / 1ps

module rnm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rnm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         data_byte,
  input  logic               shift_in,  // advance from the left neighbour
  input  logic               eps_in,    // closure from the left neighbour
  output logic               shift_out,
  output logic               eps_out,
  output logic               post_out   // new frontier bit after closure
);

  logic [7:0] byte_r;
  logic       is_any_r;
  logic       starred_r;
  logic       act_r;
  logic       act_nxt;

  logic match;
  logic hit;
  logic pre;

  assign match = is_any_r | (byte_r == data_byte);
  assign hit   = act_r & ctrl.in_use & ctrl.step & match;

  // a starred atom loops on itself, a plain one hands on to the right
  assign shift_out = hit & ~starred_r;
  assign pre       = ctrl.seed | shift_in | (hit & starred_r);
  assign post_out  = pre | eps_in;
  assign eps_out   = post_out & starred_r & ctrl.in_use;

  always_comb begin
    act_nxt = act_r;
    if (ctrl.clr) begin
      act_nxt = 1'b0;
    end else if (ctrl.upd) begin
      act_nxt = post_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      byte_r    <= data_byte;
      is_any_r  <= (data_byte == rnm_pkg::ANY_BYTE);
      starred_r <= 1'b0;
    end else if (ctrl.star_en) begin
      starred_r <= 1'b1;
    end
  end

endmodule

/* hw/rtl/regex_nfa_matcher.sv */
// Regex NFA matcher: literal, '.' and postfix '*', full-string match.
// A row of MAX_ATOMS rnm_cell instances; depends on rnm_pkg.
//
// Usage: items on in_item carry an op and a byte. Clear and append ops
// build the pattern, one atom per cell; start-of-text and text-byte ops
// run the text. Every accepted item gives exactly one result on out_item:
// matched (text so far matches the whole pattern) and dropped (pattern
// byte lost because every cell is in use).
// The result is registered and valid on the cycle after acceptance.
// Throughput is one item per cycle while in_stall is low; the frontier
// moves through all cells and its epsilon closure ripples left to right
// along the chain within the cycle that accepts the item.
// While a result waits under out_stall, in_stall is raised and the
// waiting result holds; a result taken in the same cycle frees the slot.
// Reset empties the pattern and the frontier and drops any pending
// result. Atom contents are not cleared; only cells below the atom count
// are ever used.
`timescale 1ns / 1ps

module regex_nfa_matcher #(
  parameter int MAX_ATOMS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rnm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rnm_pkg::out_item_t out_item
);

  localparam int TW = $clog2(MAX_ATOMS + 1);

  logic [TW-1:0]       atom_total_r, atom_total_nxt;
  logic                star_allowed_r, star_allowed_nxt;
  logic                out_valid_r, out_valid_nxt;
  rnm_pkg::out_item_t  out_item_r, out_item_nxt;

  logic accept;
  logic is_clear, is_append, is_start, is_text;
  logic is_star, table_full;

  rnm_pkg::cell_ctrl_t   ctrl  [MAX_ATOMS];
  logic [MAX_ATOMS-1:0]  shift_c;
  logic [MAX_ATOMS-1:0]  eps_c;
  logic [MAX_ATOMS:0]    post_vec;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign is_clear  = accept & (in_item.op == rnm_pkg::OP_CLEAR);
  assign is_append = accept & (in_item.op == rnm_pkg::OP_APPEND);
  assign is_start  = accept & (in_item.op == rnm_pkg::OP_START);
  assign is_text   = accept & (in_item.op == rnm_pkg::OP_TEXT);
  assign is_star   = (in_item.data_byte == rnm_pkg::STAR_BYTE);
  assign table_full = (atom_total_r == TW'(MAX_ATOMS));

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ATOMS; gi++) begin : g_cell
      logic sh_in, ep_in;

      always_comb begin
        ctrl[gi].wr_en   = is_append & ~is_star & (atom_total_r == TW'(gi));
        ctrl[gi].star_en = is_append & is_star & star_allowed_r &
                           (atom_total_r == TW'(gi + 1));
        ctrl[gi].in_use  = (TW'(gi) < atom_total_r);
        ctrl[gi].step    = is_text;
        ctrl[gi].seed    = (gi == 0) ? is_start : 1'b0;
        ctrl[gi].upd     = is_start | is_text;
        ctrl[gi].clr     = is_clear | is_append;
      end

      if (gi == 0) begin : g_head
        assign sh_in = 1'b0;
        assign ep_in = 1'b0;
      end else begin : g_link
        assign sh_in = shift_c[gi-1];
        assign ep_in = eps_c[gi-1];
      end

      rnm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl[gi]),
        .data_byte (in_item.data_byte),
        .shift_in  (sh_in),
        .eps_in    (ep_in),
        .shift_out (shift_c[gi]),
        .eps_out   (eps_c[gi]),
        .post_out  (post_vec[gi])
      );
    end
  endgenerate

  // position past the last cell: only reached, never stored
  assign post_vec[MAX_ATOMS] = shift_c[MAX_ATOMS-1] | eps_c[MAX_ATOMS-1];

  always_comb begin
    atom_total_nxt   = atom_total_r;
    star_allowed_nxt = star_allowed_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_item_nxt     = out_item_r;
    if (accept) begin
      out_valid_nxt        = 1'b1;
      out_item_nxt.matched = 1'b0;
      out_item_nxt.dropped = 1'b0;
    end
    if (is_clear) begin
      atom_total_nxt   = '0;
      star_allowed_nxt = 1'b0;
    end else if (is_append) begin
      if (is_star) begin
        star_allowed_nxt = 1'b0;
      end else if (table_full) begin
        star_allowed_nxt     = 1'b0;
        out_item_nxt.dropped = 1'b1;
      end else begin
        atom_total_nxt   = atom_total_r + TW'(1);
        star_allowed_nxt = 1'b1;
      end
    end else if (is_start | is_text) begin
      out_item_nxt.matched = post_vec[atom_total_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_total_r   <= '0;
      star_allowed_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      atom_total_r   <= atom_total_nxt;
      star_allowed_r <= star_allowed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    atom_total_r <= TW'(MAX_ATOMS))
    else $error("atom count beyond cell count");

  a_star_needs_atom: assert property (@(posedge clk) disable iff (!rst_n)
    star_allowed_r |-> (atom_total_r != '0))
    else $error("star allowed with empty pattern");

  a_drop_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.dropped |-> !out_item_r.matched)
    else $error("dropped and matched on one item");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    is_clear |=> (atom_total_r == '0) && !star_allowed_r)
    else $error("clear left atoms behind");
`endif

endmodule
